[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Word types, round constants, initial hash values and rotate helper.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  // Working variables a..h, index 0 is a
  typedef word_t [0:7] work_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadMarker  = 8'h80;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam work_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

[design/sha256_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step per use.
// ----------------------------------------------------------------------------
module sha256_round
  import sha256_pkg::*;
(
  input  work_t work_i,
  input  word_t k_i,
  input  word_t w0_i,
  input  word_t w1_i,
  input  word_t w9_i,
  input  word_t w14_i,
  output work_t work_o,
  output word_t w_new_o
);

  word_t big_s1, big_s0, ch, maj, t1, t2, sml_s0, sml_s1;

  always_comb begin
    big_s1 = ror(work_i[4], 6) ^ ror(work_i[4], 11) ^ ror(work_i[4], 25);
    ch     = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    t1     = work_i[7] + big_s1 + ch + k_i + w0_i;
    big_s0 = ror(work_i[0], 2) ^ ror(work_i[0], 13) ^ ror(work_i[0], 22);
    maj    = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t2     = big_s0 + maj;

    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];

    // Expand the word needed sixteen rounds ahead
    sml_s0  = ror(w1_i, 7) ^ ror(w1_i, 18) ^ (w1_i >> 3);
    sml_s1  = ror(w14_i, 17) ^ ror(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = w0_i + sml_s0 + w9_i + sml_s1;
  end

endmodule

[design/sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 streaming hasher
// Byte-serial SHA-256 with one shared round unit and in-place padding.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): kind_i = 0 carries one message byte
// in data_byte_i, kind_i = 1 finishes the message. Output channel
// (out_valid_o/out_ready_i): eight transactions carry the digest, H0 first,
// word_index_o counts 0..7 and last_o marks the eighth.
// Data bytes stream in back to back while idle. Every 64th byte starts a
// compression: 64 rounds through the single round unit plus one
// feed-forward step, with in_ready_o low throughout. A finish pushes the
// padding bytes (0x80, zeros, 8 length bytes) one per cycle through the
// same byte path, with one or two compressions in between, then offers the
// eight digest words, one per cycle while out_ready_i is high. A stalled
// receiver holds the current word and the block stays busy. After the
// eighth word the chaining words return to the initial hash values and
// in_ready_o rises again. Reset loads the initial hash values and clears
// counts; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam int unsigned BufBits = BlockBytes * 8;

  logic [2:0]         state_q, state_d;
  logic [5:0]         fill_q, fill_d;
  logic [60:0]        cnt_q, cnt_d;
  logic [63:0]        len_q, len_d;
  logic [BufBits-1:0] buf_q, buf_d;
  work_t              work_q, work_d, work_nxt;
  work_t              chain_q, chain_d;
  logic [5:0]         rnd_q, rnd_d;
  logic [2:0]         idx_q, idx_d;
  logic               pad_q, pad_d;
  logic               first_q, first_d;
  logic               lenph_q, lenph_d;
  logic               push;
  logic [7:0]         push_byte;
  word_t              w_new;

  sha256_round u_round (
    .work_i  (work_q),
    .k_i     (RoundK[rnd_q]),
    .w0_i    (buf_q[BufBits-1 -: 32]),
    .w1_i    (buf_q[BufBits-33 -: 32]),
    .w9_i    (buf_q[BufBits-289 -: 32]),
    .w14_i   (buf_q[BufBits-449 -: 32]),
    .work_o  (work_nxt),
    .w_new_o (w_new)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[0];
  assign word_index_o  = idx_q;
  assign last_o        = (idx_q == 3'd7);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    buf_d     = buf_q;
    work_d    = work_q;
    chain_d   = chain_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    pad_d     = pad_q;
    first_d   = first_q;
    lenph_d   = lenph_q;
    push      = 1'b0;
    push_byte = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!kind_i) begin
            push      = 1'b1;
            push_byte = data_byte_i;
            cnt_d     = cnt_q + 61'd1;
          end else begin
            len_d   = {cnt_q, 3'b000};
            pad_d   = 1'b1;
            first_d = 1'b1;
            lenph_d = 1'b0;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (first_q) begin
          push_byte = PadMarker;
          first_d   = 1'b0;
        end else if (fill_q == 6'(LenOffset) || lenph_q) begin
          // Length goes out most significant byte first
          push_byte = len_q[63:56];
          len_d     = {len_q[55:0], 8'h00};
          lenph_d   = 1'b1;
        end
      end
      ST_COMP: begin
        work_d = work_nxt;
        buf_d  = {buf_q[BufBits-33:0], w_new};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (lenph_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          for (int i = 0; i < 7; i++) begin
            chain_d[i] = chain_q[i+1];
          end
          chain_d[7] = chain_q[7];
          if (idx_q == 3'd7) begin
            chain_d = InitHash;
            cnt_d   = '0;
            pad_d   = 1'b0;
            lenph_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Append one byte; a full block starts the compression
    if (push) begin
      buf_d = {buf_q[BufBits-9:0], push_byte};
      if (fill_q == 6'(BlockBytes - 1)) begin
        fill_d  = '0;
        work_d  = chain_q;
        rnd_d   = '0;
        state_d = ST_COMP;
      end else begin
        fill_d = fill_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      chain_q <= InitHash;
      rnd_q   <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      lenph_q <= lenph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    buf_q  <= buf_d;
    work_q <= work_d;
  end

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COMP) |-> (rnd_q == 6'd0))
    else $error("round counter not parked outside compression");

  a_finish_pads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i) |=> (state_q == ST_PAD && first_q))
    else $error("finish did not start padding");

  a_last_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=>
      (in_ready_o && chain_q[0] == InitHash[0] && cnt_q == 61'd0))
    else $error("state not reinitialized after digest");

  a_data_add_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && !pad_q) |=> in_ready_o)
    else $error("data block compression did not return to idle");

  a_out_only_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pad_q && lenph_q && fill_q == 6'd0))
    else $error("digest offered without completed padding");

endmodule
